@@ rtl/lse_pkg.sv @@
// Package for the LSB stego embed/extract unit.
// Shared types, register indexes and codes; no dependencies.
package lse_pkg;

  localparam int ByteW     = 8;
  localparam int BufW      = 16;
  localparam int CountW    = 5;
  localparam int NW        = 4;
  localparam int LenW      = 16;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 16;

  localparam logic [CfgIdxW-1:0] REG_BITS_PER_BYTE = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_MODE          = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_MESSAGE_LEN   = 2'd2;

  localparam logic MODE_EMBED   = 1'b0;
  localparam logic MODE_EXTRACT = 1'b1;
  localparam logic OP_LOAD      = 1'b0;
  localparam logic OP_CARRIER   = 1'b1;
  localparam logic KIND_CARRIER = 1'b0;
  localparam logic KIND_MESSAGE = 1'b1;

  typedef struct packed {
    logic [NW-1:0]   bits_per_byte;
    logic            mode;
    logic [LenW-1:0] message_length;
  } lse_cfg_t;

  typedef struct packed {
    logic [BufW-1:0]   bit_buffer;
    logic [CountW-1:0] bit_count;
    logic [LenW-1:0]   bytes_recovered;
  } lse_state_t;

  typedef struct packed {
    logic             valid;
    logic [ByteW-1:0] out_byte;
    logic             kind;
  } lse_result_t;

endpackage

@@ rtl/lse_in_if.sv @@
// Input channel of the LSB stego unit: valid/ready plus one item.
// Depends on lse_pkg for field widths.
interface lse_in_if;
  logic                      valid;
  logic                      ready;
  logic                      opcode;
  logic [lse_pkg::ByteW-1:0] message_byte;
  logic [lse_pkg::ByteW-1:0] carrier_byte;

  modport source (output valid, output opcode, output message_byte,
                  output carrier_byte, input ready);
  modport sink (input valid, input opcode, input message_byte,
                input carrier_byte, output ready);
endinterface

@@ rtl/lse_out_if.sv @@
// Result channel of the LSB stego unit: valid/ready plus one result.
// Depends on lse_pkg for field widths.
interface lse_out_if;
  logic                      valid;
  logic                      ready;
  logic [lse_pkg::ByteW-1:0] out_byte;
  logic                      kind;

  modport source (output valid, output out_byte, output kind, input ready);
  modport sink (input valid, input out_byte, input kind, output ready);
endinterface

@@ rtl/lse_step.sv @@
// Per-beat datapath of the LSB stego unit: next bit-buffer state and result.
// Depends on lse_pkg.
module lse_step (
  input  lse_pkg::lse_cfg_t              cfg,
  input  lse_pkg::lse_state_t            state,
  input  logic                           opcode,
  input  logic [lse_pkg::ByteW-1:0]      message_byte,
  input  logic [lse_pkg::ByteW-1:0]      carrier_byte,
  output lse_pkg::lse_state_t            state_nxt,
  output lse_pkg::lse_result_t           result
);

  logic [lse_pkg::NW-1:0]     n;
  logic [lse_pkg::ByteW-1:0]  nmask;
  logic [lse_pkg::NW-1:0]     k;
  logic [lse_pkg::CountW-1:0] rest;
  logic [lse_pkg::ByteW-1:0]  kmask;
  logic [lse_pkg::BufW-1:0]   shifted;
  logic [lse_pkg::ByteW-1:0]  bits0;
  logic [lse_pkg::ByteW-1:0]  bits;
  logic [lse_pkg::BufW-1:0]   rest_mask;
  logic [lse_pkg::NW-1:0]     c;
  logic [lse_pkg::BufW-1:0]   b;
  logic [lse_pkg::BufW-1:0]   b2;
  logic [lse_pkg::CountW-1:0] c2;
  logic [lse_pkg::CountW-1:0] c3;
  logic [lse_pkg::BufW-1:0]   b2_shift;
  logic [lse_pkg::BufW-1:0]   c3_mask;

  // n clamped to 1..8 and the related masks
  always_comb begin
    if (cfg.bits_per_byte == 4'd0) begin
      n = 4'd1;
    end else if (cfg.bits_per_byte > 4'd8) begin
      n = 4'd8;
    end else begin
      n = cfg.bits_per_byte;
    end
    nmask = 8'hFF >> (4'd8 - n);
  end

  // embed path
  always_comb begin
    k         = (state.bit_count < {1'b0, n}) ? state.bit_count[3:0] : n;
    rest      = state.bit_count - {1'b0, k};
    kmask     = 8'hFF >> (4'd8 - k);
    shifted   = state.bit_buffer >> rest;
    bits0     = shifted[7:0] & kmask;
    bits      = (bits0 << (n - k)) & nmask;
    rest_mask = 16'hFFFF >> (5'd16 - rest);
  end

  // extract path
  always_comb begin
    c        = (state.bit_count > 5'd7) ? 4'd7 : state.bit_count[3:0];
    b        = (state.bit_count > 5'd7) ? {9'd0, state.bit_buffer[6:0]} :
               state.bit_buffer;
    b2       = (b << n) | {8'd0, carrier_byte & nmask};
    c2       = {1'b0, c} + {1'b0, n};
    c3       = c2 - 5'd8;
    b2_shift = b2 >> c3;
    c3_mask  = 16'hFFFF >> (5'd16 - c3);
  end

  always_comb begin
    state_nxt       = state;
    result.valid    = 1'b0;
    result.out_byte = carrier_byte;
    result.kind     = lse_pkg::KIND_CARRIER;
    if (cfg.mode == lse_pkg::MODE_EMBED) begin
      if (opcode == lse_pkg::OP_LOAD) begin
        if (state.bit_count <= 5'd8) begin
          state_nxt.bit_buffer = {state.bit_buffer[7:0], message_byte};
          state_nxt.bit_count  = state.bit_count + 5'd8;
        end
      end else begin
        result.valid = 1'b1;
        if (state.bit_count != 5'd0) begin
          result.out_byte      = (carrier_byte & ~nmask) | bits;
          state_nxt.bit_buffer = state.bit_buffer & rest_mask;
          state_nxt.bit_count  = rest;
        end
      end
    end else if (opcode == lse_pkg::OP_CARRIER &&
                 state.bytes_recovered < cfg.message_length) begin
      if (c2 < 5'd8) begin
        state_nxt.bit_buffer = b2;
        state_nxt.bit_count  = c2;
      end else begin
        result.valid              = 1'b1;
        result.kind               = lse_pkg::KIND_MESSAGE;
        result.out_byte           = b2_shift[7:0];
        state_nxt.bit_buffer      = b2 & c3_mask;
        state_nxt.bit_count       = c3;
        state_nxt.bytes_recovered = state.bytes_recovered + 16'd1;
      end
    end
  end

endmodule

@@ rtl/lsb_stego_embed_extract_unit.sv @@
// LSB steganography embed/extract unit, n message bits per carrier byte, MSB first.
// A beat is accepted in any cycle with in_ch.ready high; the bit buffer updates at the
// accepting edge and the result, if any, lands in a single output register at that
// edge. in_ch.ready is high whenever that register is empty or being drained, so
// the unit sustains one beat per clock while the sink keeps up. Depends on lse_pkg,
// lse_in_if, lse_out_if and lse_step. Configuration writes belong to idle periods.
module lsb_stego_embed_extract_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  lse_in_if.sink                         in_ch,
  lse_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [lse_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [lse_pkg::CfgDataW-1:0]   cfg_wdata
);

  lse_pkg::lse_cfg_t    cfg_r;
  lse_pkg::lse_state_t  state_r;
  lse_pkg::lse_state_t  state_nxt;
  lse_pkg::lse_result_t result;
  logic                 out_valid_r;
  logic [lse_pkg::ByteW-1:0] out_byte_r;
  logic                 out_kind_r;
  logic                 accept;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_byte = out_byte_r;
  assign out_ch.kind     = out_kind_r;

  lse_step u_step (
    .cfg          (cfg_r),
    .state        (state_r),
    .opcode       (in_ch.opcode),
    .message_byte (in_ch.message_byte),
    .carrier_byte (in_ch.carrier_byte),
    .state_nxt    (state_nxt),
    .result       (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bits_per_byte  <= 4'd1;
      cfg_r.mode           <= lse_pkg::MODE_EMBED;
      cfg_r.message_length <= '0;
      state_r              <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lse_pkg::REG_BITS_PER_BYTE: begin
          cfg_r.bits_per_byte <= cfg_wdata[3:0];
        end
        lse_pkg::REG_MODE: begin
          cfg_r.mode <= cfg_wdata[0];
          state_r    <= '0;
        end
        lse_pkg::REG_MESSAGE_LEN: begin
          cfg_r.message_length    <= cfg_wdata;
          state_r.bytes_recovered <= '0;
        end
        default: begin
        end
      endcase
    end else if (accept) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= result.valid;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && result.valid) begin
      out_byte_r <= result.out_byte;
      out_kind_r <= result.kind;
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.bit_count <= 5'd16)
    else $error("bit count above 16");

  a_extract_count: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_r.mode == lse_pkg::MODE_EXTRACT |-> state_r.bit_count <= 5'd7)
    else $error("extract mode holds a whole byte of pending bits");

  a_kind_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_kind_r == cfg_r.mode)
    else $error("result kind does not match mode");

  a_recovered_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.bytes_recovered <= cfg_r.message_length)
    else $error("recovered more bytes than message length");
`endif

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// Testbench for lsb_stego_embed_extract_unit: directed and random embed/extract traffic
// with a built-in predictor and an in-order result check. Uses lse_pkg, lse_in_if, lse_out_if.
module tb;

  localparam logic [lse_pkg::CfgIdxW-1:0] REG_UNUSED = 2'd3;
  localparam int unsigned PhaseItems = 205;

  typedef struct packed {
    logic                      opcode;
    logic [lse_pkg::ByteW-1:0] message_byte;
    logic [lse_pkg::ByteW-1:0] carrier_byte;
  } stego_item_t;

  typedef struct packed {
    logic [lse_pkg::ByteW-1:0] out_byte;
    logic                      kind;
  } stego_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [lse_pkg::CfgIdxW-1:0] cfg_index = lse_pkg::REG_BITS_PER_BYTE;
  logic [lse_pkg::CfgDataW-1:0] cfg_wdata = '0;

  lse_in_if in_bus ();
  lse_out_if out_bus ();

  lsb_stego_embed_extract_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_bus),
    .out_ch    (out_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #6 clk = ~clk;

  // predictor state and register shadow
  logic [lse_pkg::NW-1:0]     m_bits = 4'd1;
  logic                       m_mode = lse_pkg::MODE_EMBED;
  logic [lse_pkg::LenW-1:0]   m_length = '0;
  logic [lse_pkg::BufW-1:0]   m_buf = '0;
  logic [lse_pkg::CountW-1:0] m_count = '0;
  logic [lse_pkg::LenW-1:0]   m_recovered = '0;

  stego_item_t   pending_items[$];
  stego_result_t awaited_results[$];
  stego_item_t   drive_item;
  stego_result_t seen_result;
  int unsigned   errors = 0;
  int unsigned   send_idle_pct = 0;
  int unsigned   recv_idle_pct = 0;
  logic          hold_input = 1'b0;

  function automatic void stego_predict(input stego_item_t it);
    logic [3:0]    n;
    logic [31:0]   nmask;
    logic [31:0]   take;
    logic [31:0]   remain;
    logic [31:0]   slot;
    stego_result_t res;
    if (m_bits == 4'd0) n = 4'd1;
    else if (m_bits > 4'd8) n = 4'd8;
    else n = m_bits;
    nmask = (32'd1 << n) - 32'd1;
    if (m_mode == lse_pkg::MODE_EMBED) begin
      if (it.opcode == lse_pkg::OP_LOAD) begin
        if (m_count <= 5'd8) begin
          m_buf = {m_buf[7:0], it.message_byte};
          m_count = m_count + 5'd8;
        end
        return;
      end
      res.kind = lse_pkg::KIND_CARRIER;
      if (m_count == 5'd0) begin
        res.out_byte = it.carrier_byte;
      end else begin
        take = (m_count < n) ? 32'(m_count) : 32'(n);
        remain = 32'(m_count) - take;
        slot = ({16'd0, m_buf} >> remain) & ((32'd1 << take) - 32'd1);
        slot = (slot << (32'(n) - take)) & nmask;
        m_buf = m_buf & 16'((32'd1 << remain) - 32'd1);
        m_count = 5'(remain);
        res.out_byte = (it.carrier_byte & ~nmask[7:0]) | slot[7:0];
      end
      awaited_results.push_back(res);
      return;
    end
    if (it.opcode == lse_pkg::OP_LOAD || m_recovered >= m_length) return;
    if (m_count > 5'd7) begin
      m_count = 5'd7;
      m_buf = m_buf & 16'h007F;
    end
    m_buf = 16'(({16'd0, m_buf} << n) | ({24'd0, it.carrier_byte} & nmask));
    m_count = m_count + 5'(n);
    if (m_count < 5'd8) return;
    m_count = m_count - 5'd8;
    res.kind = lse_pkg::KIND_MESSAGE;
    res.out_byte = 8'({16'd0, m_buf} >> m_count);
    m_buf = m_buf & 16'((32'd1 << m_count) - 32'd1);
    m_recovered = m_recovered + 16'd1;
    awaited_results.push_back(res);
  endfunction

  function automatic void shadow_reg(input logic [lse_pkg::CfgIdxW-1:0] idx,
                                     input logic [lse_pkg::CfgDataW-1:0] val);
    case (idx)
      lse_pkg::REG_BITS_PER_BYTE: m_bits = val[lse_pkg::NW-1:0];
      lse_pkg::REG_MODE: begin
        m_mode = val[0];
        m_buf = '0;
        m_count = '0;
        m_recovered = '0;
      end
      lse_pkg::REG_MESSAGE_LEN: begin
        m_length = val;
        m_recovered = '0;
      end
      default: ;
    endcase
  endfunction

  // driver: one beat offered at a time, held until accepted
  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready)
        stego_predict('{opcode: in_bus.opcode, message_byte: in_bus.message_byte,
                        carrier_byte: in_bus.carrier_byte});
      if (!in_bus.valid || in_bus.ready) begin
        if (pending_items.size() != 0 && !hold_input &&
            $urandom_range(99) >= send_idle_pct) begin
          drive_item = pending_items.pop_front();
          in_bus.valid <= 1'b1;
          in_bus.opcode <= drive_item.opcode;
          in_bus.message_byte <= drive_item.message_byte;
          in_bus.carrier_byte <= drive_item.carrier_byte;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result beat with the oldest prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (awaited_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result: expected none, actual byte %h kind %b",
                   $time, out_bus.out_byte, out_bus.kind);
        end else begin
          seen_result = awaited_results.pop_front();
          if (seen_result.out_byte !== out_bus.out_byte) begin
            errors++;
            $display("%0t: out_byte mismatch: expected %h, actual %h",
                     $time, seen_result.out_byte, out_bus.out_byte);
          end
          if (seen_result.kind !== out_bus.kind) begin
            errors++;
            $display("%0t: kind mismatch: expected %b, actual %b",
                     $time, seen_result.kind, out_bus.kind);
          end
        end
      end
      out_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic push_item(input logic op, input logic [7:0] msg, input logic [7:0] car);
    stego_item_t it;
    it.opcode = op;
    it.message_byte = msg;
    it.carrier_byte = car;
    pending_items.push_back(it);
  endtask

  task automatic write_reg(input logic [lse_pkg::CfgIdxW-1:0] idx,
                           input logic [lse_pkg::CfgDataW-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow_reg(idx, val);
  endtask

  // sampled mid-cycle so the driver's pops and beats have settled
  task automatic wait_idle();
    @(negedge clk);
    while (pending_items.size() != 0 || in_bus.valid || out_bus.valid ||
           awaited_results.size() != 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
    @(posedge clk);
    send_idle_pct <= send_pct;
    recv_idle_pct <= recv_pct;
  endtask

  // load bytes followed by runs of carriers, with some stray beats mixed in
  task automatic queue_embed(input int unsigned count);
    int unsigned made;
    made = 0;
    while (made < count) begin
      if ($urandom_range(99) < 15) begin
        push_item($urandom_range(1) ? lse_pkg::OP_CARRIER : lse_pkg::OP_LOAD,
                  8'($urandom), 8'($urandom));
        made++;
      end else begin
        push_item(lse_pkg::OP_LOAD, 8'($urandom), 8'($urandom));
        made++;
        if ($urandom_range(2) != 0) begin
          push_item(lse_pkg::OP_LOAD, 8'($urandom), 8'($urandom));
          made++;
        end
        repeat ($urandom_range(1, 18)) begin
          push_item(lse_pkg::OP_CARRIER, 8'($urandom), 8'($urandom));
          made++;
        end
      end
    end
  endtask

  task automatic queue_extract(input int unsigned count);
    int unsigned made;
    made = 0;
    while (made < count) begin
      if ($urandom_range(99) < 10) begin
        push_item(lse_pkg::OP_LOAD, 8'($urandom), 8'($urandom));
      end else begin
        push_item(lse_pkg::OP_CARRIER, 8'($urandom), 8'($urandom));
      end
      made++;
    end
  endtask

  initial begin
    logic [lse_pkg::NW-1:0]   n_raw;
    logic                     mode_sel;
    logic [lse_pkg::LenW-1:0] len_sel;
    in_bus.valid = 1'b0;
    in_bus.opcode = lse_pkg::OP_LOAD;
    in_bus.message_byte = '0;
    in_bus.carrier_byte = '0;
    out_bus.ready = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    set_idling(12, 74);
    // empty buffer after reset: carriers pass unchanged
    push_item(lse_pkg::OP_CARRIER, 8'h00, 8'hFF);
    push_item(lse_pkg::OP_CARRIER, 8'hFF, 8'h00);
    wait_idle();
    write_reg(lse_pkg::REG_BITS_PER_BYTE, 16'd3);
    // fill the buffer, drop a load on a full buffer, then drain with zero padding
    push_item(lse_pkg::OP_LOAD, 8'hFF, 8'h00);
    push_item(lse_pkg::OP_LOAD, 8'h00, 8'hFF);
    push_item(lse_pkg::OP_LOAD, 8'h5A, 8'hFF);
    push_item(lse_pkg::OP_CARRIER, 8'h00, 8'hFF);
    push_item(lse_pkg::OP_CARRIER, 8'hFF, 8'h00);
    push_item(lse_pkg::OP_CARRIER, 8'h00, 8'hAA);
    push_item(lse_pkg::OP_CARRIER, 8'hFF, 8'h55);
    push_item(lse_pkg::OP_CARRIER, 8'h00, 8'hFF);
    push_item(lse_pkg::OP_CARRIER, 8'hFF, 8'h00);
    push_item(lse_pkg::OP_CARRIER, 8'h00, 8'hFF);
    wait_idle();
    write_reg(lse_pkg::REG_BITS_PER_BYTE, 16'd8);
    write_reg(lse_pkg::REG_MODE, {15'd0, lse_pkg::MODE_EXTRACT});
    write_reg(lse_pkg::REG_MESSAGE_LEN, 16'd2);
    // load ignored while extracting; third carrier arrives after the message is done
    push_item(lse_pkg::OP_LOAD, 8'h12, 8'h34);
    push_item(lse_pkg::OP_CARRIER, 8'hFF, 8'h00);
    push_item(lse_pkg::OP_CARRIER, 8'h00, 8'hFF);
    push_item(lse_pkg::OP_CARRIER, 8'hFF, 8'hA5);
    wait_idle();
    write_reg(lse_pkg::REG_MESSAGE_LEN, 16'd0);
    push_item(lse_pkg::OP_CARRIER, 8'h00, 8'h33);
    wait_idle();

    for (int ph = 0; ph < 9; ph++) begin
      if (ph == 3) set_idling(74, 12);
      if (ph == 6) set_idling(0, 0);
      case (ph)
        0: begin
          n_raw = 4'd1;
          mode_sel = lse_pkg::MODE_EMBED;
          len_sel = 16'd0;
        end
        1: begin
          n_raw = 4'd8;
          mode_sel = lse_pkg::MODE_EXTRACT;
          len_sel = 16'hFFFF;
        end
        2: begin
          n_raw = 4'd0;
          mode_sel = lse_pkg::MODE_EXTRACT;
          len_sel = 16'd20;
        end
        3: begin
          n_raw = 4'd15;
          mode_sel = lse_pkg::MODE_EMBED;
          len_sel = 16'($urandom);
        end
        4: begin
          n_raw = 4'($urandom_range(2, 7));
          mode_sel = lse_pkg::MODE_EXTRACT;
          len_sel = 16'hFFFF;
        end
        5: begin
          n_raw = 4'($urandom);
          mode_sel = lse_pkg::MODE_EMBED;
          len_sel = 16'($urandom);
        end
        6: begin
          n_raw = 4'd4;
          mode_sel = lse_pkg::MODE_EXTRACT;
          len_sel = 16'($urandom_range(1, 40));
        end
        7: begin
          n_raw = 4'($urandom_range(1, 8));
          mode_sel = lse_pkg::MODE_EMBED;
          len_sel = 16'($urandom);
        end
        default: begin
          n_raw = 4'($urandom);
          mode_sel = lse_pkg::MODE_EXTRACT;
          len_sel = 16'hFFFF;
        end
      endcase
      write_reg(REG_UNUSED, 16'($urandom));
      write_reg(lse_pkg::REG_BITS_PER_BYTE, {12'($urandom), n_raw});
      write_reg(lse_pkg::REG_MODE, {15'($urandom), mode_sel});
      write_reg(lse_pkg::REG_MESSAGE_LEN, len_sel);
      if (mode_sel == lse_pkg::MODE_EMBED) queue_embed(PhaseItems);
      else queue_extract(PhaseItems);
      if (ph == 4) begin
        while (pending_items.size() > 100) @(posedge clk);
        hold_input <= 1'b1;
        @(posedge clk);
        while (in_bus.valid || awaited_results.size() != 0) @(posedge clk);
        hold_input <= 1'b0;
      end
      wait_idle();
    end

    repeat (8) @(posedge clk);
    if (awaited_results.size() != 0) errors++;
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
